>>> rtl/srctl_pkg.sv
// ----------------------------------------------------------------------------
// srctl_pkg
// Shared types, codes and constants of the stepper ramp controller.
// ----------------------------------------------------------------------------
package srctl_pkg;

    // Default values of the top-level parameters.
    localparam int COUNT_BITS_DEF   = 24;
    localparam int TICKS_PER_MS_DEF = 1000;

    // Fixed field widths.
    localparam int KIND_W  = 2;
    localparam int STEPS_W = 24;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int OUT_W   = 64;

    // Divider geometry.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    // Arithmetic constants.
    localparam logic [31:0] MIN_RPM_Q16   = 32'd40 << 16;
    localparam logic [15:0] MIN_RPM       = 16'd40;
    localparam int          MS_PER_MIN    = 60000;
    localparam int          IDLE_DELAY_MS = 100000;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [6:0]  RAMP_DIV      = 7'd120;

    // Register reset values.
    localparam logic [15:0] SPR_RST   = 16'd200;
    localparam logic [15:0] RPM_RST   = 16'd60;
    localparam logic [15:0] ACCEL_RST = 16'd100;

    // Input word kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_MOVE    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_BAD     = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_RUN     = 2'd0,
        STAT_DONE    = 2'd1,
        STAT_LIMIT   = 2'd2,
        STAT_IGNORED = 2'd3
    } stat_t;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_SPR   = 2'd0,
        REG_RPM   = 2'd1,
        REG_ACCEL = 2'd2,
        REG_RAMP  = 2'd3
    } reg_idx_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_STOP,
        OP_MOVE_SETUP,
        OP_RELEASE,
        OP_IGNORE,
        OP_RAMP_PREP,
        OP_DIV_ACCS,
        OP_ACCS_SAVE,
        OP_DIV_DELTA,
        OP_DELTA_APPLY,
        OP_MUL_DLY,
        OP_DIV_DLY,
        OP_DELAY_SAVE,
        OP_DELAY_IDLE,
        OP_STEP,
        OP_MUL_SQ,
        OP_MUL_SQ_SPR,
        OP_DIV_DX,
        OP_DX_SAVE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              moving;
        logic              limit_hit;
        logic              due;
        logic              ramp_en;
        logic              spr_zero;
        logic              dly_idle;
        logic              div_done;
        logic              out_free;
    } dp_status_t;

    // Coil pattern for each of the four phases.
    function automatic logic [3:0] phase_bits(input logic [1:0] ph);
        logic [3:0] b;
        unique case (ph)
            2'd0: b = 4'd5;
            2'd1: b = 4'd6;
            2'd2: b = 4'd10;
            default: b = 4'd9;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/srctl_div.sv
// ----------------------------------------------------------------------------
// srctl_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend over a
// 32-bit divisor.
// ----------------------------------------------------------------------------
module srctl_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [srctl_pkg::DIV_NUM_W-1:0]    num,
    input  logic [srctl_pkg::DIV_DEN_W-1:0]    den,
    output logic [srctl_pkg::DIV_NUM_W-1:0]    quot,
    output logic                               done
);

    logic [srctl_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [srctl_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [srctl_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [srctl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [srctl_pkg::DIV_DEN_W:0]   trial;
    logic [srctl_pkg::DIV_DEN_W:0]   diff;
    logic                            ge;

    // One trial subtraction per cycle.
    assign trial = {rem_reg, num_reg[srctl_pkg::DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[srctl_pkg::DIV_NUM_W-2:0], ge};
            rem_next = ge ? diff[srctl_pkg::DIV_DEN_W-1:0]
                          : trial[srctl_pkg::DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule

>>> rtl/srctl_dp.sv
// ----------------------------------------------------------------------------
// srctl_dp
// Datapath: configuration registers, motion state, multiplier, divider and
// the output word register.
// ----------------------------------------------------------------------------
module srctl_dp
#(
    parameter int COUNT_BITS   = srctl_pkg::COUNT_BITS_DEF,
    parameter int TICKS_PER_MS = srctl_pkg::TICKS_PER_MS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  srctl_pkg::cmd_t                   cmd,
    output srctl_pkg::dp_status_t             status,
    input  logic                              cfg_valid,
    input  logic [srctl_pkg::IDX_W-1:0]       cfg_index,
    input  logic [srctl_pkg::CFG_W-1:0]       cfg_data,
    input  logic [srctl_pkg::KIND_W-1:0]      in_kind,
    input  logic [srctl_pkg::STEPS_W-1:0]     in_steps,
    input  logic                              in_lmin,
    input  logic                              in_lmax,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [srctl_pkg::OUT_W-1:0]       out_data
);

    localparam logic [63:0] DLY_NUM  = 64'(srctl_pkg::MS_PER_MIN) * 64'(TICKS_PER_MS);
    localparam logic [63:0] IDLE_NUM = 64'(srctl_pkg::IDLE_DELAY_MS) * 64'(TICKS_PER_MS);
    localparam logic [31:0] IDLE_DLY = (IDLE_NUM > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : IDLE_NUM[31:0];

    // Configuration registers.
    logic [15:0] spr_reg, rpm_reg, accel_reg;
    logic        ramp_reg;

    // Latched input word.
    logic [srctl_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [srctl_pkg::STEPS_W-1:0] steps_reg, steps_next;
    logic                          lmin_reg, lmin_next, lmax_reg, lmax_next;

    // Motion state.
    logic [15:0]           pos_reg, pos_next;
    logic                  fwd_reg, fwd_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] done_reg, done_next;
    logic [COUNT_BITS-1:0] ramp_reg_steps, ramp_steps_next;
    logic [31:0]           elapsed_reg, elapsed_next;
    logic [31:0]           delay_reg, delay_next;
    logic [31:0]           speed_reg, speed_next;
    logic                  moving_reg, moving_next;
    logic [3:0]            coils_reg, coils_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  taken_reg, taken_next;

    // Arithmetic work registers.
    logic [31:0] s_reg, s_next;
    logic [21:0] accs_reg, accs_next;
    logic [47:0] prod_reg, prod_next;

    // Output word.
    logic                        ov_reg, ov_next;
    logic [srctl_pkg::OUT_W-1:0] od_reg, od_next;

    // Divider hookup.
    logic                                div_start;
    logic [srctl_pkg::DIV_NUM_W-1:0]     div_num;
    logic [srctl_pkg::DIV_DEN_W-1:0]     div_den;
    logic [srctl_pkg::DIV_NUM_W-1:0]     div_q;
    logic                                div_done;

    // Helper values.
    logic [23:0]           mag;
    logic [15:0]           accel_eff;
    logic [21:0]           acc60;
    logic [22:0]           acc120;
    logic [COUNT_BITS-1:0] half;
    logic [COUNT_BITS-1:0] rem_dec;
    logic [15:0]           pos_step;
    logic [16:0]           pos_inc;
    logic [63:0]           sum;
    logic [31:0]           s_ramp;

    srctl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    assign mag       = -steps_reg;
    assign accel_eff = (accel_reg == '0) ? 16'd1 : accel_reg;
    assign acc60     = 22'(accel_reg) * 22'(srctl_pkg::SEC_PER_MIN);
    assign acc120    = 23'(accel_eff) * 23'(srctl_pkg::RAMP_DIV);
    assign half      = rem_reg >> 1;
    assign rem_dec   = rem_reg - 1'b1;
    assign pos_inc   = {1'b0, pos_reg} + 17'd1;

    // Next position of one step in the travel direction.
    always_comb
    begin
        if (fwd_reg)
            pos_step = (pos_inc >= {1'b0, spr_reg}) ? 16'd0 : pos_inc[15:0];
        else if (pos_reg == '0)
            pos_step = (spr_reg != '0) ? spr_reg - 1'b1 : 16'd0;
        else
            pos_step = pos_reg - 1'b1;
    end

    // Ramp speed update from the divided increment.
    always_comb
    begin
        sum    = 64'(s_reg) + div_q;
        s_ramp = s_reg;
        if (done_reg < ramp_reg_steps)
            s_ramp = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        else if ((rem_reg < ramp_reg_steps) && (s_reg > srctl_pkg::MIN_RPM_Q16))
            s_ramp = (div_q >= 64'(s_reg - srctl_pkg::MIN_RPM_Q16))
                     ? srctl_pkg::MIN_RPM_Q16 : s_reg - div_q[31:0];
    end

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = DLY_NUM;
        div_den   = prod_reg[31:0];
        unique case (cmd.op)
            srctl_pkg::OP_DIV_ACCS:
            begin
                div_start = 1'b1;
                div_num   = 64'(acc60);
                div_den   = 32'(spr_reg);
            end
            srctl_pkg::OP_DIV_DELTA:
            begin
                div_start = 1'b1;
                div_num   = {10'd0, accs_reg, 32'd0};
                div_den   = s_reg;
            end
            srctl_pkg::OP_DIV_DX:
            begin
                div_start = 1'b1;
                div_num   = 64'(prod_reg);
                div_den   = 32'(acc120);
            end
            srctl_pkg::OP_DIV_DLY:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Operation decode.
    always_comb
    begin
        kind_next       = kind_reg;
        steps_next      = steps_reg;
        lmin_next       = lmin_reg;
        lmax_next       = lmax_reg;
        pos_next        = pos_reg;
        fwd_next        = fwd_reg;
        rem_next        = rem_reg;
        done_next       = done_reg;
        ramp_steps_next = ramp_reg_steps;
        elapsed_next    = elapsed_reg;
        delay_next      = delay_reg;
        speed_next      = speed_reg;
        moving_next     = moving_reg;
        coils_next      = coils_reg;
        stat_next       = stat_reg;
        taken_next      = taken_reg;
        s_next          = s_reg;
        accs_next       = accs_reg;
        prod_next       = prod_reg;
        ov_next         = ov_reg && !out_ready;
        od_next         = od_reg;
        unique case (cmd.op)
            srctl_pkg::OP_LOAD:
            begin
                kind_next  = in_kind;
                steps_next = in_steps;
                lmin_next  = in_lmin;
                lmax_next  = in_lmax;
                stat_next  = srctl_pkg::STAT_RUN;
                taken_next = 1'b0;
            end
            srctl_pkg::OP_TICK:
            begin
                if (elapsed_reg != '1)
                    elapsed_next = elapsed_reg + 1'b1;
            end
            srctl_pkg::OP_STOP:
            begin
                moving_next = 1'b0;
                stat_next   = srctl_pkg::STAT_LIMIT;
            end
            srctl_pkg::OP_MOVE_SETUP:
            begin
                if (steps_reg[23])
                begin
                    rem_next = COUNT_BITS'(mag);
                    fwd_next = 1'b0;
                end
                else
                begin
                    rem_next = COUNT_BITS'(steps_reg);
                    if (steps_reg != '0)
                        fwd_next = 1'b1;
                end
                done_next       = '0;
                ramp_steps_next = '0;
                s_next          = ramp_reg ? srctl_pkg::MIN_RPM_Q16 : {rpm_reg, 16'd0};
                speed_next      = s_next;
                moving_next     = (rem_next != '0);
                stat_next       = moving_next ? srctl_pkg::STAT_RUN : srctl_pkg::STAT_DONE;
            end
            srctl_pkg::OP_RELEASE:
            begin
                coils_next = '0;
            end
            srctl_pkg::OP_IGNORE:
            begin
                stat_next = srctl_pkg::STAT_IGNORED;
            end
            srctl_pkg::OP_RAMP_PREP:
            begin
                s_next    = (speed_reg < srctl_pkg::MIN_RPM_Q16) ? srctl_pkg::MIN_RPM_Q16
                                                                 : speed_reg;
                accs_next = '0;
            end
            srctl_pkg::OP_ACCS_SAVE:
            begin
                accs_next = div_q[21:0];
            end
            srctl_pkg::OP_DELTA_APPLY:
            begin
                s_next     = s_ramp;
                speed_next = s_ramp;
            end
            srctl_pkg::OP_MUL_DLY:
            begin
                prod_next = 48'(32'(spr_reg) * 32'(s_reg[31:16]));
            end
            srctl_pkg::OP_DELAY_SAVE:
            begin
                delay_next = (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
            end
            srctl_pkg::OP_DELAY_IDLE:
            begin
                delay_next = IDLE_DLY;
            end
            srctl_pkg::OP_STEP:
            begin
                elapsed_next = '0;
                pos_next     = pos_step;
                rem_next     = rem_dec;
                done_next    = done_reg + 1'b1;
                coils_next   = srctl_pkg::phase_bits(pos_step[1:0]);
                taken_next   = 1'b1;
                if (rem_dec == '0)
                begin
                    moving_next = 1'b0;
                    stat_next   = srctl_pkg::STAT_DONE;
                end
            end
            srctl_pkg::OP_MUL_SQ:
            begin
                prod_next = 48'(32'(rpm_reg) * 32'(rpm_reg));
            end
            srctl_pkg::OP_MUL_SQ_SPR:
            begin
                prod_next = 48'(prod_reg[31:0]) * 48'(spr_reg);
            end
            srctl_pkg::OP_DX_SAVE:
            begin
                ramp_steps_next = (div_q < 64'(half)) ? COUNT_BITS'(div_q) : half;
            end
            srctl_pkg::OP_EMIT:
            begin
                ov_next = 1'b1;
                od_next = {speed_reg[31:16],
                           ~(lmin_reg & lmax_reg),
                           stat_reg,
                           taken_reg,
                           24'(rem_reg),
                           pos_reg,
                           coils_reg};
            end
            default:
            begin
                kind_next = kind_reg;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg   <= srctl_pkg::SPR_RST;
            rpm_reg   <= srctl_pkg::RPM_RST;
            accel_reg <= srctl_pkg::ACCEL_RST;
            ramp_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (srctl_pkg::reg_idx_t'(cfg_index))
                srctl_pkg::REG_SPR:   spr_reg   <= cfg_data;
                srctl_pkg::REG_RPM:   rpm_reg   <= cfg_data;
                srctl_pkg::REG_ACCEL: accel_reg <= cfg_data;
                srctl_pkg::REG_RAMP:  ramp_reg  <= cfg_data[0];
                default:              ramp_reg  <= ramp_reg;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= '0;
            steps_reg      <= '0;
            lmin_reg       <= 1'b1;
            lmax_reg       <= 1'b1;
            pos_reg        <= '0;
            fwd_reg        <= 1'b0;
            rem_reg        <= '0;
            done_reg       <= '0;
            ramp_reg_steps <= '0;
            elapsed_reg    <= '1;
            delay_reg      <= '0;
            speed_reg      <= '0;
            moving_reg     <= 1'b0;
            coils_reg      <= '0;
            stat_reg       <= '0;
            taken_reg      <= 1'b0;
            s_reg          <= '0;
            accs_reg       <= '0;
            prod_reg       <= '0;
            ov_reg         <= 1'b0;
            od_reg         <= '0;
        end
        else
        begin
            kind_reg       <= kind_next;
            steps_reg      <= steps_next;
            lmin_reg       <= lmin_next;
            lmax_reg       <= lmax_next;
            pos_reg        <= pos_next;
            fwd_reg        <= fwd_next;
            rem_reg        <= rem_next;
            done_reg       <= done_next;
            ramp_reg_steps <= ramp_steps_next;
            elapsed_reg    <= elapsed_next;
            delay_reg      <= delay_next;
            speed_reg      <= speed_next;
            moving_reg     <= moving_next;
            coils_reg      <= coils_next;
            stat_reg       <= stat_next;
            taken_reg      <= taken_next;
            s_reg          <= s_next;
            accs_reg       <= accs_next;
            prod_reg       <= prod_next;
            ov_reg         <= ov_next;
            od_reg         <= od_next;
        end
    end

    // Status toward the controller.
    assign status.kind      = kind_reg;
    assign status.moving    = moving_reg;
    assign status.limit_hit = (!lmin_reg && !fwd_reg) || (!lmax_reg && fwd_reg);
    assign status.due       = (elapsed_reg >= delay_reg);
    assign status.ramp_en   = ramp_reg;
    assign status.spr_zero  = (spr_reg == '0);
    assign status.dly_idle  = (spr_reg == '0) || (s_reg[31:16] == '0);
    assign status.div_done  = div_done;
    assign status.out_free  = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

>>> rtl/srctl_ctrl.sv
// ----------------------------------------------------------------------------
// srctl_ctrl
// Controller: sequences the datapath through decode, ramp update, delay
// computation, step and result output for each input word.
// ----------------------------------------------------------------------------
module srctl_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  srctl_pkg::dp_status_t status,
    output srctl_pkg::cmd_t       cmd
);

    typedef enum logic [16:0] {
        ST_IDLE       = 17'h00001,
        ST_DECODE     = 17'h00002,
        ST_EVAL       = 17'h00004,
        ST_RAMP       = 17'h00008,
        ST_ACCS_GO    = 17'h00010,
        ST_ACCS_WAIT  = 17'h00020,
        ST_DELTA_GO   = 17'h00040,
        ST_DELTA_WAIT = 17'h00080,
        ST_DLY_SEL    = 17'h00100,
        ST_DLY_GO     = 17'h00200,
        ST_DLY_WAIT   = 17'h00400,
        ST_STEP       = 17'h00800,
        ST_DX_SQ      = 17'h01000,
        ST_DX_MUL     = 17'h02000,
        ST_DX_GO      = 17'h04000,
        ST_DX_WAIT    = 17'h08000,
        ST_EMIT       = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   is_tick;

    assign is_tick  = (status.kind == srctl_pkg::KIND_TICK);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = srctl_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = srctl_pkg::OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (is_tick)
                begin
                    cmd.op     = srctl_pkg::OP_TICK;
                    state_next = ST_EVAL;
                end
                else if (status.kind == srctl_pkg::KIND_MOVE && !status.moving)
                begin
                    cmd.op     = srctl_pkg::OP_MOVE_SETUP;
                    state_next = status.ramp_en ? ST_DX_SQ : ST_DLY_SEL;
                end
                else if (status.kind == srctl_pkg::KIND_RELEASE && !status.moving)
                begin
                    cmd.op     = srctl_pkg::OP_RELEASE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.op     = srctl_pkg::OP_IGNORE;
                    state_next = ST_EMIT;
                end
            end
            ST_EVAL:
            begin
                if (!status.moving)
                    state_next = ST_EMIT;
                else if (status.limit_hit)
                begin
                    cmd.op     = srctl_pkg::OP_STOP;
                    state_next = ST_EMIT;
                end
                else if (status.due)
                    state_next = status.ramp_en ? ST_RAMP : ST_STEP;
                else
                    state_next = ST_EMIT;
            end
            ST_RAMP:
            begin
                cmd.op     = srctl_pkg::OP_RAMP_PREP;
                state_next = status.spr_zero ? ST_DELTA_GO : ST_ACCS_GO;
            end
            ST_ACCS_GO:
            begin
                cmd.op     = srctl_pkg::OP_DIV_ACCS;
                state_next = ST_ACCS_WAIT;
            end
            ST_ACCS_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = srctl_pkg::OP_ACCS_SAVE;
                    state_next = ST_DELTA_GO;
                end
            end
            ST_DELTA_GO:
            begin
                cmd.op     = srctl_pkg::OP_DIV_DELTA;
                state_next = ST_DELTA_WAIT;
            end
            ST_DELTA_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = srctl_pkg::OP_DELTA_APPLY;
                    state_next = ST_DLY_SEL;
                end
            end
            ST_DLY_SEL:
            begin
                if (status.dly_idle)
                begin
                    cmd.op     = srctl_pkg::OP_DELAY_IDLE;
                    state_next = is_tick ? ST_STEP : ST_EMIT;
                end
                else
                begin
                    cmd.op     = srctl_pkg::OP_MUL_DLY;
                    state_next = ST_DLY_GO;
                end
            end
            ST_DLY_GO:
            begin
                cmd.op     = srctl_pkg::OP_DIV_DLY;
                state_next = ST_DLY_WAIT;
            end
            ST_DLY_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = srctl_pkg::OP_DELAY_SAVE;
                    state_next = is_tick ? ST_STEP : ST_EMIT;
                end
            end
            ST_STEP:
            begin
                cmd.op     = srctl_pkg::OP_STEP;
                state_next = ST_EMIT;
            end
            ST_DX_SQ:
            begin
                cmd.op     = srctl_pkg::OP_MUL_SQ;
                state_next = ST_DX_MUL;
            end
            ST_DX_MUL:
            begin
                cmd.op     = srctl_pkg::OP_MUL_SQ_SPR;
                state_next = ST_DX_GO;
            end
            ST_DX_GO:
            begin
                cmd.op     = srctl_pkg::OP_DIV_DX;
                state_next = ST_DX_WAIT;
            end
            ST_DX_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = srctl_pkg::OP_DX_SAVE;
                    state_next = ST_DLY_SEL;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = srctl_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/stepper_ramp_controller_unit.sv
// ----------------------------------------------------------------------------
// stepper_ramp_controller_unit
// Four-wire stepper driver with constant-speed or trapezoidal ramp moves.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Word
//  s_*       in         s_tvalid/s_tready  tick, move or release command
//  m_*       out        m_tvalid/m_tready  one result word per command
//  cfg_*     in         cfg_valid/cfg_ready register index and value
//
//  A ramp step runs up to three passes of the shared divider; a move runs
//  up to one, or up to two with the ramp enabled.
//  Reset leaves position 0, coils off and the block ready for a word.
//  A waiting result sits in the output register while the next word is taken;
//  a second result waits until the first one leaves, with s_tready low.
// ----------------------------------------------------------------------------
module stepper_ramp_controller_unit
#(
    parameter int COUNT_BITS   = srctl_pkg::COUNT_BITS_DEF,
    parameter int TICKS_PER_MS = srctl_pkg::TICKS_PER_MS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // step_count[23:0], limit_min_low[24], limit_max_low[25], zero pad
    input  logic [31:0]                   s_tdata,
    // kind[1:0]
    input  logic [srctl_pkg::KIND_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // coils[3:0], position[19:4], remaining[43:20], step_taken[44],
    // status[46:45], blocked[47], profile_speed[63:48]
    output logic [srctl_pkg::OUT_W-1:0]   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srctl_pkg::IDX_W-1:0]   cfg_index,
    input  logic [srctl_pkg::CFG_W-1:0]   cfg_data
);

    srctl_pkg::cmd_t       cmd;
    srctl_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    srctl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srctl_dp
    #(
        .COUNT_BITS   (COUNT_BITS),
        .TICKS_PER_MS (TICKS_PER_MS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (s_tuser),
        .in_steps  (s_tdata[23:0]),
        .in_lmin   (s_tdata[24]),
        .in_lmax   (s_tdata[25]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // A word taken starts processing; no second word enters next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // A new result appears only from the output load step.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.op == srctl_pkg::OP_EMIT))
        else $error("result valid without output load");

    // A step never comes with a limit stop or an ignored command.
    a_step_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[44] |-> (m_tdata[46:45] == srctl_pkg::STAT_RUN) ||
                                     (m_tdata[46:45] == srctl_pkg::STAT_DONE))
        else $error("step reported with wrong status");

endmodule
